>>> src/hdar_pkg.sv
// hdar_pkg: shared types and constants of the search-result table
// request and result payload structs, stored entry layout, action codes
// no dependencies
package hdar_pkg;

   localparam int INDEX_BITS    = 16;
   localparam int TAG_BITS      = 16;
   localparam int KEY_BITS      = 64;
   localparam int SLOT_OUT_BITS = 16;

   typedef enum logic [2:0] {
      ACT_DROP  = 3'd0,
      ACT_AGE   = 3'd1,
      ACT_SAME  = 3'd2,
      ACT_OTHER = 3'd3,
      ACT_EMPTY = 3'd4
   } action_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [15:0]         best_move;
      logic [15:0]         score_bound;
      logic                is_exact;
      logic [7:0]          search_depth;
      logic [7:0]          search_age;
   } req_type;

   typedef struct packed {
      action_type               action;
      logic [SLOT_OUT_BITS-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic [7:0]          age;
      logic [7:0]          depth;
      logic                exact;
   } meta_type;

   typedef struct packed {
      logic [15:0] best_move;
      logic [15:0] score_bound;
   } payload_type;

endpackage

>>> src/hash_table_depth_age_replacement.sv
// hash_table_depth_age_replacement: direct-mapped search-result table, top level
// holds the tag/meta and payload memories and the store policy
// depends on hdar_pkg
//
// One request can be accepted every cycle unless a held result stalls the pipe;
// each request is read from memory into the stage-one registers, then decided,
// written back and loaded into the result register. The tag/meta memory has one
// synchronous read port and one write port; a request that reads the slot being
// written back in the same cycle gets the new entry by forwarding. After reset a
// clearing pass writes blank entries to every slot, one per cycle; no request is
// accepted until it ends. The slot field reports the low 16 bits of the table
// index.
module hash_table_depth_age_replacement
   import hdar_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   meta_type    meta_mem    [2**INDEX_BITS];
   payload_type payload_mem [2**INDEX_BITS];

   logic                  clr_busy_ff, clr_busy_in;
   logic [INDEX_BITS-1:0] clr_addr_ff, clr_addr_in;

   logic     s1_valid_ff, s1_valid_in;
   req_type  s1_req_ff;
   meta_type rd_meta_ff;
   logic     fwd_hit_ff;
   meta_type fwd_meta_ff;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic                  req_acc;
   logic                  out_free;
   logic                  s1_adv;
   logic [INDEX_BITS-1:0] req_slot;
   logic [INDEX_BITS-1:0] s1_slot;
   logic [TAG_BITS-1:0]   s1_tag;
   meta_type              cur_meta;
   meta_type              new_meta;
   action_type            act;
   logic                  full_wr;
   logic                  deeper;
   logic                  match;

   logic                  meta_we;
   logic                  payload_we;
   logic [INDEX_BITS-1:0] wr_addr;
   meta_type              meta_wd;
   payload_type           payload_wd;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !clr_busy_ff && (!s1_valid_ff || out_free);
   assign req_acc   = req_valid && req_ready;
   assign req_slot  = req_payload.key[INDEX_BITS-1:0];

   // store policy
   always_comb begin
      cur_meta = fwd_hit_ff ? fwd_meta_ff : rd_meta_ff;
      s1_slot  = s1_req_ff.key[INDEX_BITS-1:0];
      s1_tag   = s1_req_ff.key[KEY_BITS-1 -: TAG_BITS];
      deeper   = s1_req_ff.search_depth > cur_meta.depth;
      match    = cur_meta.tag == s1_tag;
      full_wr  = 1'b0;
      new_meta = cur_meta;
      priority if (!deeper && s1_req_ff.search_age == cur_meta.age) begin
         act = ACT_DROP;
      end else if (!deeper && match &&
                   (s1_req_ff.search_depth != cur_meta.depth ||
                    cur_meta.exact || !s1_req_ff.is_exact)) begin
         act          = ACT_AGE;
         new_meta.age = s1_req_ff.search_age;
      end else begin
         full_wr = 1'b1;
         if (match) begin
            act = ACT_SAME;
         end else if (cur_meta.tag != '0) begin
            act = ACT_OTHER;
         end else begin
            act = ACT_EMPTY;
         end
         new_meta.tag   = s1_tag;
         new_meta.age   = s1_req_ff.search_age;
         new_meta.depth = s1_req_ff.search_depth;
         new_meta.exact = s1_req_ff.is_exact;
      end
   end

   // write port shared by clearing pass and write-back
   always_comb begin
      meta_we    = clr_busy_ff || (s1_adv && act != ACT_DROP);
      payload_we = clr_busy_ff || (s1_adv && full_wr);
      wr_addr    = clr_busy_ff ? clr_addr_ff : s1_slot;
      meta_wd    = clr_busy_ff ? '0 : new_meta;
      payload_wd = clr_busy_ff ? '0 :
                   payload_type'({s1_req_ff.best_move, s1_req_ff.score_bound});
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[wr_addr] <= meta_wd;
      end
      if (payload_we) begin
         payload_mem[wr_addr] <= payload_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_meta_ff  <= meta_mem[req_slot];
         s1_req_ff   <= req_payload;
         fwd_meta_ff <= new_meta;
      end
   end

   // next values
   always_comb begin
      clr_busy_in = clr_busy_ff && (clr_addr_ff != '1);
      clr_addr_in = clr_busy_ff ? clr_addr_ff + 1'b1 : clr_addr_ff;
      s1_valid_in = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_acc) begin
            fwd_hit_ff <= s1_adv && (act != ACT_DROP) && (s1_slot == req_slot);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff.action <= act;
         rsp_ff.slot   <= SLOT_OUT_BITS'(s1_slot);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_ready)
      else $error("request accepted during clearing pass");

   a_wb_fills_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("write-back without result");

   a_meta_write_source: assert property (@(posedge clock) disable iff (reset)
      meta_we |-> (clr_busy_ff || s1_valid_ff))
      else $error("meta write with no source");

   a_fwd_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !s1_adv) |=> !fwd_hit_ff)
      else $error("forward without preceding write-back");
`endif

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking bench for the direct-mapped search-result table
// queue-fed request driver, clocked monitor with its own store-policy predictor
// depends on hdar_pkg and hash_table_depth_age_replacement
module tb_top;
   import hdar_pkg::*;

   localparam int SLOTS = 1 << INDEX_BITS;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   req_type     pending_requests[$];
   rsp_type     expected_results[$];
   meta_type    entry_meta[SLOTS];
   payload_type entry_payload[SLOTS];

   int unsigned send_idle_pct = 15;
   int unsigned recv_idle_pct = 74;
   int unsigned mismatches = 0;
   int unsigned accepted_requests = 0;
   int unsigned checked_results = 0;
   int unsigned action_counts[5] = '{default: 0};

   logic [TAG_BITS-1:0]   hot_tags[4];
   logic [INDEX_BITS-1:0] hot_slots[8];
   logic [7:0]            search_age_now = 8'd10;

   hash_table_depth_age_replacement u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic rsp_type predict_store(input req_type r);
      logic [INDEX_BITS-1:0] idx;
      logic [TAG_BITS-1:0]   tag;
      meta_type              cur;
      logic                  hit;
      logic                  deeper;
      rsp_type               res;
      idx    = r.key[INDEX_BITS-1:0];
      tag    = r.key[KEY_BITS-1 -: TAG_BITS];
      cur    = entry_meta[idx];
      hit    = (cur.tag == tag);
      deeper = (r.search_depth > cur.depth);
      if (!deeper && r.search_age == cur.age) begin
         res.action = ACT_DROP;
      end else if (!deeper && hit &&
                   (r.search_depth != cur.depth || cur.exact || !r.is_exact)) begin
         entry_meta[idx].age = r.search_age;
         res.action = ACT_AGE;
      end else begin
         if (hit) begin
            res.action = ACT_SAME;
         end else if (cur.tag != '0) begin
            res.action = ACT_OTHER;
         end else begin
            res.action = ACT_EMPTY;
         end
         entry_meta[idx] = '{tag: tag, age: r.search_age, depth: r.search_depth,
                             exact: r.is_exact};
         entry_payload[idx] = '{best_move: r.best_move, score_bound: r.score_bound};
      end
      res.slot = SLOT_OUT_BITS'(idx);
      return res;
   endfunction

   function automatic logic [KEY_BITS-1:0] make_key(input logic [TAG_BITS-1:0] tag,
                                                    input logic [INDEX_BITS-1:0] idx);
      logic [KEY_BITS-1:0] k;
      k = {$urandom, $urandom};
      k[INDEX_BITS-1:0] = idx;
      k[KEY_BITS-1 -: TAG_BITS] = tag;
      return k;
   endfunction

   task automatic queue_request(input logic [KEY_BITS-1:0] key, input logic [15:0] mv,
                                input logic [15:0] sb, input logic ex,
                                input logic [7:0] depth, input logic [7:0] age);
      req_type r;
      r.key          = key;
      r.best_move    = mv;
      r.score_bound  = sb;
      r.is_exact     = ex;
      r.search_depth = depth;
      r.search_age   = age;
      pending_requests.push_back(r);
   endtask

   // mostly a few hot slots and tags with nearby ages so the policy gets exercised
   task automatic queue_random_request();
      logic [TAG_BITS-1:0]   tag;
      logic [INDEX_BITS-1:0] idx;
      logic [7:0]            depth;
      logic [7:0]            age;
      if ($urandom_range(19) == 0) search_age_now = search_age_now + 8'd1;
      if ($urandom_range(99) < 15) begin
         tag   = TAG_BITS'($urandom);
         idx   = INDEX_BITS'($urandom);
         depth = 8'($urandom);
         age   = 8'($urandom);
      end else begin
         tag   = hot_tags[$urandom_range(3)];
         idx   = hot_slots[$urandom_range(7)];
         depth = 8'($urandom_range(12));
         age   = search_age_now - 8'($urandom_range(2));
      end
      queue_request(make_key(tag, idx), 16'($urandom), 16'($urandom),
                    1'($urandom), depth, age);
   endtask

   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_requests.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_store(req_payload));
            accepted_requests++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result at %0t: action %0d slot %h",
                           $time, rsp_payload.action, rsp_payload.slot);
            end else begin
               exp_rsp = expected_results.pop_front();
               checked_results++;
               action_counts[exp_rsp.action]++;
               if (rsp_payload.action !== exp_rsp.action ||
                   rsp_payload.slot !== exp_rsp.slot) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at %0t: expected action %0d slot %h, got action %0d slot %h",
                              $time, exp_rsp.action, exp_rsp.slot,
                              rsp_payload.action, rsp_payload.slot);
               end
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         entry_meta[i]    = '0;
         entry_payload[i] = '0;
      end
      hot_tags[0] = '0;
      hot_tags[1] = '1;
      hot_tags[2] = TAG_BITS'($urandom);
      hot_tags[3] = TAG_BITS'($urandom);
      hot_slots[0] = '0;
      hot_slots[1] = '1;
      for (int i = 2; i < 8; i++) hot_slots[i] = INDEX_BITS'($urandom);

      // zero tag on a blank slot: drop, refresh, exact rewrite, then another tag fills it
      queue_request(make_key('0, '0), 16'h0000, 16'h0000, 1'b0, 8'd0, 8'd0);
      queue_request(make_key('0, '0), 16'h1111, 16'h2222, 1'b0, 8'd0, 8'd1);
      queue_request(make_key('0, '0), 16'h3333, 16'h4444, 1'b1, 8'd0, 8'd2);
      queue_request(make_key('1, '0), 16'h5555, 16'h6666, 1'b0, 8'd0, 8'd3);
      // deeper with the same age still writes
      queue_request(make_key('1, '0), 16'h7777, 16'h8888, 1'b0, 8'd5, 8'd3);
      queue_request(make_key(TAG_BITS'(16'h1234), '0), 16'h9999, 16'haaaa,
                    1'b0, 8'd2, 8'd4);
      queue_request('1, 16'hffff, 16'hffff, 1'b1, 8'd255, 8'd255);
      queue_request('1, 16'h0000, 16'h0000, 1'b0, 8'd255, 8'd255);
      queue_request('1, 16'h0f0f, 16'hf0f0, 1'b0, 8'd255, 8'd0);
      queue_request(make_key(TAG_BITS'(1) << (TAG_BITS-1), '1), 16'h0001, 16'h8000,
                    1'b1, 8'd254, 8'd0);
      queue_request(make_key(TAG_BITS'(1) << (TAG_BITS-1), '1), 16'h8000, 16'h0001,
                    1'b0, 8'd254, 8'd1);
      queue_request(make_key(hot_tags[2], hot_slots[2]), 16'h1234, 16'h5678,
                    1'b1, 8'd3, 8'd7);
      queue_request(make_key(hot_tags[2], hot_slots[2]), 16'habcd, 16'hef01,
                    1'b1, 8'd3, 8'd8);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 230; i++) queue_random_request();
      wait_until_drained();

      send_idle_pct = 74;
      recv_idle_pct = 15;
      for (int i = 0; i < 230; i++) queue_random_request();
      wait_until_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 230; i++) queue_random_request();
      wait_until_drained();

      repeat (10) @(negedge clock);
      $display("%0d requests over three idling phases, %0d results checked",
               accepted_requests, checked_results);
      $display("drop %0d, refresh %0d, rewrite %0d, replace %0d, fill %0d",
               action_counts[ACT_DROP], action_counts[ACT_AGE], action_counts[ACT_SAME],
               action_counts[ACT_OTHER], action_counts[ACT_EMPTY]);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule

>>> sim.f
src/hdar_pkg.sv
src/hash_table_depth_age_replacement.sv
sim/tb_top.sv
